### rtl/core/bsc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bsc_pkg
// Shared types, constants and helpers of the barometric compensation pipeline.
// ----------------------------------------------------------------------------
package bsc_pkg;

    localparam int DIV_BITS = 32;

    localparam logic [1:0] CFG_TEMP  = 2'd0;
    localparam logic [1:0] CFG_PLOW  = 2'd1;
    localparam logic [1:0] CFG_PHIGH = 2'd2;
    localparam logic [1:0] CFG_PLAST = 2'd3;

    localparam logic [31:0] K_64000  = 32'd64000;
    localparam logic [31:0] K_1M     = 32'd1048576;
    localparam logic [31:0] K_3125   = 32'd3125;
    localparam logic [31:0] K_HALF   = 32'h8000_0000;
    localparam logic [31:0] K_32768  = 32'd32768;
    localparam logic [31:0] K_128    = 32'd128;

    typedef struct packed {
        logic [19:0] raw_temperature;
        logic [19:0] raw_pressure;
    } in_word_t;

    typedef struct packed {
        logic signed [31:0] fine_temperature;
        logic signed [31:0] temperature_centi;
        logic [31:0]        pressure_pa;
        logic               divide_fault;
    } out_word_t;

    typedef struct packed {
        logic [15:0] t1, t2, t3;
        logic [15:0] p1, p2, p3, p4, p5, p6, p7, p8, p9;
    } coeff_t;

    function automatic logic [31:0] sx(input logic [15:0] v);
        return {{16{v[15]}}, v};
    endfunction

    function automatic logic [31:0] mul(input logic [31:0] a, input logic [31:0] b);
        logic [63:0] p;
        p = a * b;
        return p[31:0];
    endfunction

    function automatic logic [31:0] asr(input logic [31:0] x, input int n);
        return 32'($signed(x) >>> n);
    endfunction

endpackage
`default_nettype wire

### rtl/core/bsc_div.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bsc_div
// Pipelined restoring divider, one quotient bit per stage, with side payload.
// ----------------------------------------------------------------------------
module bsc_div #(
    parameter int SIDE_W = 64
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              en,
    input  wire logic              in_vld,
    input  wire logic [31:0]       num,
    input  wire logic [31:0]       den,
    input  wire logic [SIDE_W-1:0] side_in,
    output logic                   out_vld,
    output logic [31:0]            quo,
    output logic [SIDE_W-1:0]      side_out
);
    import bsc_pkg::*;

    logic [DIV_BITS:0]   vld_reg;
    logic [31:0]         rem_reg  [DIV_BITS+1];
    logic [31:0]         q_reg    [DIV_BITS+1];
    logic [31:0]         d_reg    [DIV_BITS+1];
    logic [SIDE_W-1:0]   s_reg    [DIV_BITS+1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (en)
            vld_reg <= {vld_reg[DIV_BITS-1:0], in_vld};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0] <= '0;
            q_reg[0]   <= num;
            d_reg[0]   <= den;
            s_reg[0]   <= side_in;
        end
    end

    for (genvar i = 0; i < DIV_BITS; i++) begin : g_stage
        logic [32:0] trial;
        logic [32:0] shifted;
        assign shifted = {rem_reg[i], q_reg[i][31]};
        assign trial   = shifted - {1'b0, d_reg[i]};
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                // keep the difference when it does not borrow
                if (!trial[32])
                    rem_reg[i+1] <= trial[31:0];
                else
                    rem_reg[i+1] <= shifted[31:0];
                q_reg[i+1] <= {q_reg[i][30:0], ~trial[32]};
                d_reg[i+1] <= d_reg[i];
                s_reg[i+1] <= s_reg[i];
            end
        end
    end

    assign out_vld  = vld_reg[DIV_BITS];
    assign quo      = q_reg[DIV_BITS];
    assign side_out = s_reg[DIV_BITS];
endmodule
`default_nettype wire

### rtl/core/baro_sensor_compensation_top.sv
`default_nettype none
// Throughput: one word per cycle while the skid slot is free.
// A stall at the output freezes the whole pipeline once the skid slot is full; a
// two-entry skid buffer keeps input ready independent of output ready in the same cycle.
// Reset clears the coefficient registers to zero and all valid bits.
// ----------------------------------------------------------------------------
// baro_sensor_compensation_top
// Integer temperature and pressure compensation of raw 20-bit samples.
// ----------------------------------------------------------------------------
module baro_sensor_compensation_top (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               cfg_valid,
    output logic                    cfg_ready,
    input  wire logic [1:0]         cfg_index,
    input  wire logic [63:0]        cfg_data,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire bsc_pkg::in_word_t  in_data,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output bsc_pkg::out_word_t      out_data
);
    import bsc_pkg::*;

    // ---------------- configuration ----------------
    logic [47:0] tc_reg;
    logic [63:0] pl_reg, ph_reg;
    logic [15:0] p9_reg;
    coeff_t      c;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tc_reg <= '0;
            pl_reg <= '0;
            ph_reg <= '0;
            p9_reg <= '0;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_TEMP:  tc_reg <= cfg_data[47:0];
                CFG_PLOW:  pl_reg <= cfg_data;
                CFG_PHIGH: ph_reg <= cfg_data;
                CFG_PLAST: p9_reg <= cfg_data[15:0];
                default:   ;
            endcase
        end
    end

    assign c = '{t1: tc_reg[15:0], t2: tc_reg[31:16], t3: tc_reg[47:32],
                 p1: pl_reg[15:0], p2: pl_reg[31:16], p3: pl_reg[47:32],
                 p4: pl_reg[63:48], p5: ph_reg[15:0], p6: ph_reg[31:16],
                 p7: ph_reg[47:32], p8: ph_reg[63:48], p9: p9_reg};

    // ---------------- skid buffer at the output ----------------
    // The pipeline advances when the skid slot is free; a word leaving the pipe
    // parks in the skid when the output stalls.
    out_word_t pipe_word;
    logic      pipe_vld;
    logic      en;
    out_word_t o_reg, s_reg;
    logic      ov_reg, sv_reg;

    assign en        = !sv_reg;
    assign in_ready  = en;
    assign out_valid = ov_reg;
    assign out_data  = o_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ov_reg <= 1'b0;
            sv_reg <= 1'b0;
        end
        else
        begin
            if (!ov_reg || out_ready)
            begin
                ov_reg <= sv_reg || (en && pipe_vld);
                sv_reg <= 1'b0;
            end
            else if (en && pipe_vld)
                sv_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!ov_reg || out_ready)
            o_reg <= sv_reg ? s_reg : pipe_word;
        else if (en && pipe_vld)
            s_reg <= pipe_word;
    end

    // ---------------- stage 1: temperature products ----------------
    logic        v1_reg;
    logic [19:0] ap1_reg;
    logic [31:0] tv1_reg, dd_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) v1_reg <= 1'b0;
        else if (en) v1_reg <= in_valid;
    end
    always_ff @(posedge clk)
    begin
        logic [31:0] at, d;
        at = {12'd0, in_data.raw_temperature};
        d  = (at >> 4) - {16'd0, c.t1};
        if (en)
        begin
            ap1_reg <= in_data.raw_pressure;
            tv1_reg <= mul((at >> 3) - {15'd0, c.t1, 1'b0}, sx(c.t2));
            dd_reg  <= mul(d, d);
        end
    end

    // ---------------- stage 2: fine temperature terms ----------------
    logic        v2_reg;
    logic [19:0] ap2_reg;
    logic [31:0] tv1b_reg, tv2_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) v2_reg <= 1'b0;
        else if (en) v2_reg <= v1_reg;
    end
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ap2_reg  <= ap1_reg;
            tv1b_reg <= asr(tv1_reg, 11);
            tv2_reg  <= mul(asr(dd_reg, 12), sx(c.t3));
        end
    end

    // ---------------- stage 3: fine, centi, v1 ----------------
    logic        v3_reg;
    logic [19:0] ap3_reg;
    logic [31:0] fine3_reg, cm_reg, pv1_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) v3_reg <= 1'b0;
        else if (en) v3_reg <= v2_reg;
    end
    always_ff @(posedge clk)
    begin
        logic [31:0] f;
        f = tv1b_reg + asr(tv2_reg, 14);
        if (en)
        begin
            ap3_reg   <= ap2_reg;
            fine3_reg <= f;
            cm_reg    <= mul(f, 32'd5) + K_128;
            pv1_reg   <= asr(f, 1) - K_64000;
        end
    end

    // ---------------- stage 4: square and linear terms ----------------
    logic        v4_reg;
    logic [19:0] ap4_reg;
    logic [31:0] fine4_reg, cen4_reg, sq_reg, v1p5_reg, v1p2_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) v4_reg <= 1'b0;
        else if (en) v4_reg <= v3_reg;
    end
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ap4_reg   <= ap3_reg;
            fine4_reg <= fine3_reg;
            cen4_reg  <= asr(cm_reg, 8);
            sq_reg    <= mul(asr(pv1_reg, 2), asr(pv1_reg, 2));
            v1p5_reg  <= mul(pv1_reg, sx(c.p5));
            v1p2_reg  <= mul(sx(c.p2), pv1_reg);
        end
    end

    // ---------------- stage 5: second products ----------------
    logic        v5_reg;
    logic [19:0] ap5_reg;
    logic [31:0] fine5_reg, cen5_reg, sq6_reg, v1p5b_reg, p3sq_reg, v1p2b_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) v5_reg <= 1'b0;
        else if (en) v5_reg <= v4_reg;
    end
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ap5_reg   <= ap4_reg;
            fine5_reg <= fine4_reg;
            cen5_reg  <= cen4_reg;
            sq6_reg   <= mul(asr(sq_reg, 11), sx(c.p6));
            v1p5b_reg <= v1p5_reg;
            p3sq_reg  <= mul(sx(c.p3), asr(sq_reg, 13));
            v1p2b_reg <= v1p2_reg;
        end
    end

    // ---------------- stage 6: v2 and pre-divisor ----------------
    logic        v6_reg;
    logic [19:0] ap6_reg;
    logic [31:0] fine6_reg, cen6_reg, pv2_reg, q1_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) v6_reg <= 1'b0;
        else if (en) v6_reg <= v5_reg;
    end
    always_ff @(posedge clk)
    begin
        logic [31:0] a;
        a = sq6_reg + (v1p5b_reg << 1);
        if (en)
        begin
            ap6_reg   <= ap5_reg;
            fine6_reg <= fine5_reg;
            cen6_reg  <= cen5_reg;
            pv2_reg   <= asr(a, 2) + (sx(c.p4) << 16);
            q1_reg    <= asr(asr(p3sq_reg, 3) + asr(v1p2b_reg, 1), 18);
        end
    end

    // ---------------- stage 7: divisor and dividend ----------------
    logic        v7_reg;
    logic [31:0] fine7_reg, cen7_reg, den_reg, pn_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) v7_reg <= 1'b0;
        else if (en) v7_reg <= v6_reg;
    end
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            fine7_reg <= fine6_reg;
            cen7_reg  <= cen6_reg;
            den_reg   <= mul(K_32768 + q1_reg, {16'd0, c.p1});
            pn_reg    <= mul((K_1M - {12'd0, ap6_reg}) - asr(pv2_reg, 12), K_3125);
        end
    end

    // ---------------- stage 8: dividend select ----------------
    logic        v8_reg, big8_reg;
    logic [31:0] fine8_reg, cen8_reg, den8_reg, num8_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) v8_reg <= 1'b0;
        else if (en) v8_reg <= v7_reg;
    end
    always_ff @(posedge clk)
    begin
        logic [31:0] dv;
        dv = asr(den_reg, 15);
        if (en)
        begin
            fine8_reg <= fine7_reg;
            cen8_reg  <= cen7_reg;
            den8_reg  <= dv;
            big8_reg  <= !(pn_reg < K_HALF);
            num8_reg  <= (pn_reg < K_HALF) ? (pn_reg << 1) : pn_reg;
        end
    end

    // ---------------- divider ----------------
    localparam int SW = 32 + 32 + 1 + 1;
    logic          dvld;
    logic [31:0]   dq;
    logic [SW-1:0] dside;
    bsc_div #(.SIDE_W(SW)) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_vld   (v8_reg),
        .num      (num8_reg),
        .den      (den8_reg),
        .side_in  ({fine8_reg, cen8_reg, big8_reg, den8_reg == '0}),
        .out_vld  (dvld),
        .quo      (dq),
        .side_out (dside)
    );

    // ---------------- stage 9: correction products ----------------
    logic        v9_reg, f9_reg;
    logic [31:0] fine9_reg, cen9_reg, p9q_reg, sqp_reg, p8p_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) v9_reg <= 1'b0;
        else if (en) v9_reg <= dvld;
    end
    always_ff @(posedge clk)
    begin
        logic [31:0] p;
        p = dside[1] ? (dq << 1) : dq;
        if (en)
        begin
            fine9_reg <= dside[SW-1:34];
            cen9_reg  <= dside[33:2];
            f9_reg    <= dside[0];
            p9q_reg   <= p;
            sqp_reg   <= mul(p >> 3, p >> 3);
            p8p_reg   <= mul(p >> 2, sx(c.p8));
        end
    end

    // ---------------- stage 10: p9 product ----------------
    logic        v10_reg, f10_reg;
    logic [31:0] fine10_reg, cen10_reg, p10_reg, c9_reg, c8_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) v10_reg <= 1'b0;
        else if (en) v10_reg <= v9_reg;
    end
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            fine10_reg <= fine9_reg;
            cen10_reg  <= cen9_reg;
            f10_reg    <= f9_reg;
            p10_reg    <= p9q_reg;
            c9_reg     <= mul(sx(c.p9), sqp_reg >> 13);
            c8_reg     <= asr(p8p_reg, 13);
        end
    end

    // ---------------- stage 11: final sum ----------------
    out_word_t w11_reg;
    logic      v11_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) v11_reg <= 1'b0;
        else if (en) v11_reg <= v10_reg;
    end
    always_ff @(posedge clk)
    begin
        logic [31:0] s;
        s = asr(c9_reg, 12) + c8_reg + sx(c.p7);
        if (en)
        begin
            w11_reg.fine_temperature  <= fine10_reg;
            w11_reg.temperature_centi <= cen10_reg;
            w11_reg.divide_fault      <= f10_reg;
            // zero divisor drops the pressure to zero
            w11_reg.pressure_pa       <= f10_reg ? 32'd0 : p10_reg + asr(s, 4);
        end
    end

    assign pipe_vld  = v11_reg;
    assign pipe_word = w11_reg;
endmodule
`default_nettype wire

### tb/baro_sensor_compensation_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// baro_sensor_compensation_top_tb
// Drives raw temperature/pressure pairs through the compensation pipeline
// under several coefficient sets. A local integer model predicts each result
// word, and a monitor compares the words field by field and in order.
// ----------------------------------------------------------------------------
module baro_sensor_compensation_top_tb;
    import bsc_pkg::*;

    localparam int SETTLE_CYCLES = 60;

    logic       clk;
    logic       rst_n;
    logic       cfg_valid;
    logic       cfg_ready;
    logic [1:0] cfg_index;
    logic [63:0] cfg_data;
    logic       in_valid;
    logic       in_ready;
    in_word_t   in_data;
    logic       out_valid;
    logic       out_ready;
    out_word_t  out_data;

    // Coefficient shadow copies, updated when a register write is accepted
    logic [47:0] temp_cal;
    logic [63:0] press_cal_lo;
    logic [63:0] press_cal_hi;
    logic [15:0] press_cal_p9;

    out_word_t  pending_results[$];
    int         error_count;
    int         send_idle_pct;
    int         recv_idle_pct;

    baro_sensor_compensation_top uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    always
    begin
        clk = 1'b1;
        #2;
        clk = 1'b0;
        #2;
    end

    // Helpers for the compensation arithmetic: everything wraps at 32 bits
    function automatic logic [31:0] sra32(input logic [31:0] x, input int n);
        logic signed [31:0] s;
        s = x;
        return s >>> n;
    endfunction

    function automatic logic [31:0] mul32w(input logic [31:0] a, input logic [31:0] b);
        logic [63:0] full;
        full = {32'd0, a} * {32'd0, b};
        return full[31:0];
    endfunction

    function automatic logic [31:0] sext16(input logic [15:0] v);
        return {{16{v[15]}}, v};
    endfunction

    // Compensate one sample pair with the current coefficient copies
    function automatic out_word_t compensate_sample(input in_word_t s);
        logic [31:0] adc_t, adc_p, t1, t2, t3;
        logic [31:0] p1, p2, p3, p4, p5, p6, p7, p8, p9;
        logic [31:0] v1, v2, d, sq, fine, centi, p;
        out_word_t   r;
        adc_t = {12'd0, s.raw_temperature};
        adc_p = {12'd0, s.raw_pressure};
        t1 = {16'd0, temp_cal[15:0]};
        t2 = sext16(temp_cal[31:16]);
        t3 = sext16(temp_cal[47:32]);
        p1 = {16'd0, press_cal_lo[15:0]};
        p2 = sext16(press_cal_lo[31:16]);
        p3 = sext16(press_cal_lo[47:32]);
        p4 = sext16(press_cal_lo[63:48]);
        p5 = sext16(press_cal_hi[15:0]);
        p6 = sext16(press_cal_hi[31:16]);
        p7 = sext16(press_cal_hi[47:32]);
        p8 = sext16(press_cal_hi[63:48]);
        p9 = sext16(press_cal_p9);

        v1 = sra32(mul32w((adc_t >> 3) - (t1 << 1), t2), 11);
        d = (adc_t >> 4) - t1;
        v2 = sra32(mul32w(sra32(mul32w(d, d), 12), t3), 14);
        fine = v1 + v2;
        centi = sra32(mul32w(fine, 32'd5) + 32'd128, 8);

        v1 = sra32(fine, 1) - 32'd64000;
        sq = mul32w(sra32(v1, 2), sra32(v1, 2));
        v2 = mul32w(sra32(sq, 11), p6);
        v2 = v2 + (mul32w(v1, p5) << 1);
        v2 = sra32(v2, 2) + (p4 << 16);
        v1 = sra32(sra32(mul32w(p3, sra32(sq, 13)), 3) + sra32(mul32w(p2, v1), 1), 18);
        v1 = sra32(mul32w(32'd32768 + v1, p1), 15);

        r.fine_temperature = fine;
        r.temperature_centi = centi;
        if (v1 == 32'd0)
        begin
            r.divide_fault = 1'b1;
            r.pressure_pa = 32'd0;
        end
        else
        begin
            p = mul32w((32'd1048576 - adc_p) - sra32(v2, 12), 32'd3125);
            if (p < 32'h8000_0000)
                p = (p << 1) / v1;
            else
                p = mul32w(p / v1, 32'd2);
            v1 = sra32(mul32w(p9, mul32w(p >> 3, p >> 3) >> 13), 12);
            v2 = sra32(mul32w(p >> 2, p8), 13);
            p = p + sra32(v1 + v2 + p7, 4);
            r.divide_fault = 1'b0;
            r.pressure_pa = p;
        end
        return r;
    endfunction

    // Write one coefficient register; only called with the pipeline drained
    task automatic write_coeffs(input logic [1:0] idx, input logic [63:0] value);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (idx)
            CFG_TEMP:  temp_cal     = value[47:0];
            CFG_PLOW:  press_cal_lo = value;
            CFG_PHIGH: press_cal_hi = value;
            default:   press_cal_p9 = value[15:0];
        endcase
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Send one sample word; valid stays high across back-to-back words
    task automatic send_sample(input in_word_t s);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= s;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        pending_results.push_back(compensate_sample(s));
        @(negedge clk);
    endtask

    // Drop valid after a burst, then wait for the pipeline to drain
    task automatic drain_pipeline();
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic load_coeff_set(input logic [47:0] tc, input logic [63:0] lo,
                                  input logic [63:0] hi, input logic [15:0] p9);
        write_coeffs(CFG_TEMP, {16'd0, tc});
        write_coeffs(CFG_PLOW, lo);
        write_coeffs(CFG_PHIGH, hi);
        write_coeffs(CFG_PLAST, {48'd0, p9});
    endtask

    function automatic in_word_t random_sample();
        in_word_t s;
        s.raw_temperature = 20'($urandom);
        s.raw_pressure    = 20'($urandom);
        return s;
    endfunction

    // Realistic calibration close to a typical sensor, with slight jitter
    task automatic load_typical_coeffs();
        logic [15:0] t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
        t1 = 16'd27504 + 16'($urandom_range(200));
        t2 = 16'd26435;
        t3 = 16'hFC18;
        p1 = 16'd36477 + 16'($urandom_range(500));
        p2 = 16'hD67A;
        p3 = 16'd3024;
        p4 = 16'd2855;
        p5 = 16'd140;
        p6 = 16'hFFF9;
        p7 = 16'd15500;
        p8 = 16'hB0F8;
        p9 = 16'd6000;
        load_coeff_set({t3, t2, t1}, {p4, p3, p2, p1}, {p8, p7, p6, p5}, p9);
    endtask

    // All coefficients zero (reset values): every word raises the fault
    task automatic test_reset_coeffs();
        in_word_t s;
        s = '0;
        send_sample(s);
        s = '1;
        send_sample(s);
        drain_pipeline();
    endtask

    // Field extremes and typical values with a realistic calibration
    task automatic test_directed_extremes();
        in_word_t s;
        load_typical_coeffs();
        s.raw_temperature = 20'd519888;
        s.raw_pressure    = 20'd415148;
        send_sample(s);
        s.raw_temperature = '0;
        s.raw_pressure    = '0;
        send_sample(s);
        s.raw_temperature = '1;
        s.raw_pressure    = '1;
        send_sample(s);
        s.raw_temperature = '0;
        s.raw_pressure    = '1;
        send_sample(s);
        s.raw_temperature = '1;
        s.raw_pressure    = '0;
        send_sample(s);
        s.raw_temperature = 20'h55555;
        s.raw_pressure    = 20'hAAAAA;
        send_sample(s);
        drain_pipeline();
    endtask

    // Extreme coefficients: all ones, all sign bits, maxima; wrap-around
    task automatic test_extreme_coeffs();
        load_coeff_set('1, '1, '1, '1);
        repeat (4) send_sample(random_sample());
        drain_pipeline();
        load_coeff_set({16'h8000, 16'h8000, 16'hFFFF}, {4{16'h8000}} | 64'hFFFF,
                       {4{16'h8000}}, 16'h8000);
        repeat (4) send_sample(random_sample());
        drain_pipeline();
        load_coeff_set({16'h7FFF, 16'h7FFF, 16'h0001}, {16'h7FFF, 16'h7FFF, 16'h7FFF,
                       16'h0001}, {4{16'h7FFF}}, 16'h7FFF);
        repeat (4) send_sample(random_sample());
        drain_pipeline();
    endtask

    // Random phases: mostly realistic calibration, some random coefficients
    task automatic test_random_phase(input int send_pct, input int recv_pct,
                                     input int n_words);
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        for (int k = 0; k < n_words; k++)
        begin
            if (k % 100 == 0)
            begin
                drain_pipeline();
                if ($urandom_range(3) == 0)
                    load_coeff_set(48'({$urandom, $urandom}), {$urandom, $urandom},
                                   {$urandom, $urandom}, 16'($urandom));
                else
                    load_typical_coeffs();
            end
            send_sample(random_sample());
        end
        drain_pipeline();
    endtask

    // Receiver: stall at random, check each accepted result word in order
    always @(negedge clk)
    begin
        if (rst_n)
            out_ready <= !($urandom_range(99) < recv_idle_pct);
    end

    always @(posedge clk)
    begin
        out_word_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_results.size() == 0)
            begin
                $display("%0t: unexpected result word %h", $time, out_data);
                error_count++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (out_data.fine_temperature !== want.fine_temperature)
                begin
                    $display("%0t: fine_temperature expected %0d actual %0d", $time,
                             want.fine_temperature, out_data.fine_temperature);
                    error_count++;
                end
                if (out_data.temperature_centi !== want.temperature_centi)
                begin
                    $display("%0t: temperature_centi expected %0d actual %0d", $time,
                             want.temperature_centi, out_data.temperature_centi);
                    error_count++;
                end
                if (out_data.pressure_pa !== want.pressure_pa)
                begin
                    $display("%0t: pressure_pa expected %0d actual %0d", $time,
                             want.pressure_pa, out_data.pressure_pa);
                    error_count++;
                end
                if (out_data.divide_fault !== want.divide_fault)
                begin
                    $display("%0t: divide_fault expected %0b actual %0b", $time,
                             want.divide_fault, out_data.divide_fault);
                    error_count++;
                end
            end
        end
    end

    // Hold the run to a generous ceiling
    initial
    begin
        #2000000;
        $display("DONE: errors detected");
        $finish;
    end

    initial
    begin
        rst_n = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = CFG_TEMP;
        cfg_data = '0;
        in_valid = 1'b0;
        in_data = '0;
        out_ready = 1'b0;
        temp_cal = '0;
        press_cal_lo = '0;
        press_cal_hi = '0;
        press_cal_p9 = '0;
        error_count = 0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_reset_coeffs();
        test_directed_extremes();
        test_extreme_coeffs();
        test_random_phase(26, 67, 300);
        test_random_phase(67, 26, 300);
        test_random_phase(0, 0, 300);

        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end
endmodule
